// ===== src/lcgja_pkg.sv =====
package lcgja_pkg;

  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_INC = 32'd2531011;

  localparam int StepW = 3;
  typedef logic [StepW-1:0] step_t;

  // Microprogram addresses.
  localparam step_t STEP_ACC_MUL = 3'd0;
  localparam step_t STEP_ACC_ADD = 3'd1;
  localparam step_t STEP_CUR_ADD = 3'd2;
  localparam step_t STEP_CUR_MUL = 3'd3;
  localparam step_t STEP_FINAL   = 3'd4;

  typedef struct packed {
    logic [31:0] start_seed;
    logic [31:0] step_count;
  } in_t;

  typedef struct packed {
    logic [31:0] new_seed;
    logic [15:0] upper_half;
  } out_t;

  typedef enum logic [1:0] {
    A_ACC_MUL,
    A_ACC_ADD,
    A_CUR_MUL
  } sel_a_t;

  typedef enum logic [1:0] {
    B_CUR_MUL,
    B_CUR_ADD,
    B_SEED
  } sel_b_t;

  typedef enum logic [1:0] {
    C_ZERO,
    C_CUR_ADD,
    C_ACC_ADD
  } sel_c_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_ACC_MUL,
    DST_ACC_ADD,
    DST_CUR_ADD,
    DST_CUR_MUL,
    DST_OUT
  } dst_t;

  // BR_ROUND: skip to the target when the current exponent bit is clear,
  // or to the final step when no bits remain. BR_LAST: skip to the final
  // step when no higher bits remain. Skipped steps write nothing.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_GOTO,
    BR_ROUND,
    BR_LAST
  } br_t;

  typedef struct packed {
    sel_a_t sel_a;
    sel_b_t sel_b;
    sel_c_t sel_c;
    dst_t   dst;
    logic   shift_n;
    br_t    br;
    step_t  tgt;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic n_zero;
    logic n_bit0;
    logic n_rest_zero;
  } stat_t;

  // Control store: one multiply-accumulate a * b + c per step.
  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    unique case (pc)
      STEP_ACC_MUL:
        w = '{A_ACC_MUL, B_CUR_MUL, C_ZERO, DST_ACC_MUL, 1'b0, BR_ROUND, STEP_CUR_ADD};
      STEP_ACC_ADD:
        w = '{A_ACC_ADD, B_CUR_MUL, C_CUR_ADD, DST_ACC_ADD, 1'b0, BR_NEXT, STEP_ACC_ADD};
      STEP_CUR_ADD:
        w = '{A_CUR_MUL, B_CUR_ADD, C_CUR_ADD, DST_CUR_ADD, 1'b0, BR_LAST, STEP_FINAL};
      STEP_CUR_MUL:
        w = '{A_CUR_MUL, B_CUR_MUL, C_ZERO, DST_CUR_MUL, 1'b1, BR_GOTO, STEP_ACC_MUL};
      STEP_FINAL:
        w = '{A_ACC_MUL, B_SEED, C_ACC_ADD, DST_OUT, 1'b0, BR_NEXT, STEP_ACC_MUL};
      default:
        w = '{A_ACC_MUL, B_CUR_MUL, C_ZERO, DST_NONE, 1'b0, BR_GOTO, STEP_ACC_MUL};
    endcase
    return w;
  endfunction

endpackage

// ===== src/lcgja_datapath.sv =====
module lcgja_datapath (
  input  logic                clk,
  input  logic                load,
  input  lcgja_pkg::in_t      load_data,
  input  lcgja_pkg::ctl_t     ctl,
  input  logic                wr_en,
  output lcgja_pkg::stat_t    stat,
  output logic [31:0]         mac_res
);

  logic [31:0] seed_r;
  logic [31:0] n_r;
  logic [31:0] acc_mul_r;
  logic [31:0] acc_add_r;
  logic [31:0] cur_mul_r;
  logic [31:0] cur_add_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] op_c;

  always_comb begin
    case (ctl.sel_a)
      lcgja_pkg::A_ACC_MUL: op_a = acc_mul_r;
      lcgja_pkg::A_ACC_ADD: op_a = acc_add_r;
      default:              op_a = cur_mul_r;
    endcase
    case (ctl.sel_b)
      lcgja_pkg::B_CUR_MUL: op_b = cur_mul_r;
      lcgja_pkg::B_CUR_ADD: op_b = cur_add_r;
      default:              op_b = seed_r;
    endcase
    case (ctl.sel_c)
      lcgja_pkg::C_CUR_ADD: op_c = cur_add_r;
      lcgja_pkg::C_ACC_ADD: op_c = acc_add_r;
      default:              op_c = '0;
    endcase
  end

  // Only the low word of the product is kept, so everything wraps mod 2^32.
  // (a + 1) * c is formed as a * c + c, which keeps one unit for every step.
  assign mac_res = op_a * op_b + op_c;

  assign stat.n_zero      = (n_r == '0);
  assign stat.n_bit0      = n_r[0];
  assign stat.n_rest_zero = (n_r[31:1] == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      seed_r    <= load_data.start_seed;
      n_r       <= load_data.step_count;
      acc_mul_r <= 32'd1;
      acc_add_r <= '0;
      cur_mul_r <= lcgja_pkg::LCG_MUL;
      cur_add_r <= lcgja_pkg::LCG_INC;
    end else if (wr_en) begin
      case (ctl.dst)
        lcgja_pkg::DST_ACC_MUL: acc_mul_r <= mac_res;
        lcgja_pkg::DST_ACC_ADD: acc_add_r <= mac_res;
        lcgja_pkg::DST_CUR_ADD: cur_add_r <= mac_res;
        lcgja_pkg::DST_CUR_MUL: cur_mul_r <= mac_res;
        default: ;
      endcase
      if (ctl.shift_n) begin
        n_r <= {1'b0, n_r[31:1]};
      end
    end
  end

endmodule

// ===== src/lcg_jump_ahead.sv =====
// Channel  Ports                          Word
// input    in_valid, in_ready, in_data    start_seed, step_count
// output   out_valid, out_ready, out_data new_seed, upper_half
//
// One word is worked on at a time on a single 32x32 multiply-accumulate unit,
// one microcode step per cycle unless a held result stalls the final step. A set
// exponent bit updates the accumulators, each bit below the highest set one then
// the current pair; the final step applies the accumulators to the seed.
// Reset (rst_n low, synchronous) empties the sequencer and the output register.
// A held result stalls only the final step; a new word is taken while it waits.
module lcg_jump_ahead (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcgja_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lcgja_pkg::out_t   out_data
);

  logic                busy_r;
  logic                busy_nxt;
  lcgja_pkg::step_t    pc_r;
  lcgja_pkg::step_t    pc_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  lcgja_pkg::out_t     out_r;
  lcgja_pkg::ctl_t     ctl;
  lcgja_pkg::stat_t    stat;
  logic [31:0]         mac_res;
  logic                accept;
  logic                skip;
  lcgja_pkg::step_t    skip_tgt;
  logic                stall;
  logic                wr_en;
  logic                is_final;

  assign ctl      = lcgja_pkg::ucode(pc_r);
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign is_final = (ctl.dst == lcgja_pkg::DST_OUT);

  always_comb begin
    skip     = 1'b0;
    skip_tgt = lcgja_pkg::STEP_FINAL;
    case (ctl.br)
      lcgja_pkg::BR_ROUND: begin
        if (stat.n_zero) begin
          skip = 1'b1;
        end else if (!stat.n_bit0) begin
          skip     = 1'b1;
          skip_tgt = ctl.tgt;
        end
      end
      lcgja_pkg::BR_LAST: begin
        skip = stat.n_rest_zero;
      end
      default: ;
    endcase
  end

  assign stall = is_final && out_valid_r && !out_ready;
  assign wr_en = busy_r && !skip && !stall;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = lcgja_pkg::STEP_ACC_MUL;
    end else if (busy_r) begin
      if (skip) begin
        pc_nxt = skip_tgt;
      end else if (stall) begin
        pc_nxt = pc_r;
      end else if (is_final) begin
        busy_nxt = 1'b0;
        pc_nxt   = lcgja_pkg::STEP_ACC_MUL;
      end else if (ctl.br == lcgja_pkg::BR_GOTO) begin
        pc_nxt = ctl.tgt;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wr_en && is_final) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= lcgja_pkg::STEP_ACC_MUL;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && is_final) begin
      out_r.new_seed   <= mac_res;
      out_r.upper_half <= mac_res[31:16];
    end
  end

  lcgja_datapath u_datapath (
    .clk       (clk),
    .load      (accept),
    .load_data (in_data),
    .ctl       (ctl),
    .wr_en     (wr_en),
    .stat      (stat),
    .mac_res   (mac_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/lcgja_checker.sv =====
module lcgja_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lcgja_pkg::out_t   out_data
);

  // A held result word does not move or change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_upper_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.upper_half == out_data.new_seed[31:16])
    else $error("upper_half does not match new_seed");

  // Only one word is in flight, so the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // No result can appear in the cycle after a word is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind lcg_jump_ahead lcgja_checker u_lcgja_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
